[src/hxds_pkg.sv]
// Shared types and constants for the Hensel exact-divide shift stream block.
package hxds_pkg;

    localparam int DEFAULT_LIMB_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int SHIFT_WIDTH        = 6;
    localparam int INV_ITERATIONS     = 6;
    localparam int MUL_LAST_STEP      = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIVISOR = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT   = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QMUL,
        S_HMUL,
        S_INV_T,
        S_INV_V,
        S_EMIT_MID,
        S_EMIT_FIN
    } state_t;

endpackage

[src/hensel_exact_divide_shift_stream.sv]
// Top level: streaming exact division by an odd limb with a shifted quotient output.
//
// Input channel (in_valid/in_ready) takes one dividend limb per request, least
// significant first, with carry_in, is_first and is_last. Output channel
// (out_valid/out_ready) returns shifted quotient limbs; the request that closes
// an operand carries final_flag and the remainder. Configuration channel
// (cfg_valid/cfg_ready) writes the divisor (index 0) or the shift (index 1).
// One shared multiplier of about half the limb width builds each full product
// from four partial products. A limb needs two dependent products, computed in
// S_QMUL and S_HMUL before the output register is loaded from S_EMIT_MID or
// S_EMIT_FIN, and a new limb is taken only once the block is back in S_IDLE. A
// first limb that does not close its operand returns nothing; a last limb that
// is not also first returns two requests. A divisor write derives the inverse
// with twelve products, during which no limb is taken.
// Reset sets divisor and inverse to one, shift to zero and clears the borrow
// and the pending quotient limb. A stalled receiver holds the output register;
// one further limb may be taken and computed, then the sequencer waits.
module hensel_exact_divide_shift_stream
    import hxds_pkg::*;
#(
    parameter int LIMB_WIDTH = DEFAULT_LIMB_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [LIMB_WIDTH-1:0]      limb,
    input  logic [LIMB_WIDTH-1:0]      carry_in,
    input  logic                       is_first,
    input  logic                       is_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [LIMB_WIDTH-1:0]      quotient_limb,
    output logic [LIMB_WIDTH-1:0]      remainder,
    output logic                       final_flag,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [LIMB_WIDTH-1:0]      cfg_data
);

    localparam int LW   = LIMB_WIDTH;
    localparam int HW   = (LW + 1) / 2;
    localparam int PW   = 4 * HW;
    localparam int SW   = $clog2(LW);
    localparam int IW   = $clog2(INV_ITERATIONS);

    state_t                 state_reg, state_next;

    logic [LW-1:0]          divisor_reg, divisor_next;
    logic [LW-1:0]          inverse_reg, inverse_next;
    logic [SHIFT_WIDTH-1:0] shift_reg, shift_next;
    logic [LW-1:0]          borrow_high_reg, borrow_high_next;
    logic                   borrow_bit_reg, borrow_bit_next;
    logic [LW-1:0]          pending_reg, pending_next;
    logic                   have_pending_reg, have_pending_next;
    logic                   last_reg, last_next;
    logic                   emit_mid_reg, emit_mid_next;
    logic [LW-1:0]          mid_reg, mid_next;
    logic [IW-1:0]          iter_reg, iter_next;

    logic [LW-1:0]          mul_a_reg, mul_a_next;
    logic [LW-1:0]          mul_b_reg, mul_b_next;
    logic [2:0]             step_reg, step_next;
    logic [PW-1:0]          acc_reg, acc_next;
    logic [2*HW-1:0]        pp_reg, pp_next;

    logic                   out_valid_reg, out_valid_next;
    logic [LW-1:0]          out_q_reg, out_q_next;
    logic [LW-1:0]          out_rem_reg, out_rem_next;
    logic                   out_fin_reg, out_fin_next;

    logic [HW-1:0]          a_lo, a_hi, b_lo, b_hi;
    logic [HW-1:0]          mul_x, mul_y;
    logic [2:0]             step_m1;
    logic [PW-1:0]          pp_wide;
    logic [PW-1:0]          mul_sum;
    logic [LW-1:0]          prod_lo, prod_hi;
    logic                   mul_done;
    logic                   out_free;
    logic                   in_fire, cfg_fire;

    logic [LW-1:0]          start_bh;
    logic                   start_bb;
    logic                   borrow_out;
    logic [LW-1:0]          diff;
    logic [SW-1:0]          shift_eff;
    logic [LW-1:0]          top_bits;

    // shared multiplier: one partial product per cycle, registered, then accumulated
    assign a_lo    = mul_a_reg[HW-1:0];
    assign a_hi    = HW'(mul_a_reg[LW-1:HW]);
    assign b_lo    = mul_b_reg[HW-1:0];
    assign b_hi    = HW'(mul_b_reg[LW-1:HW]);
    assign step_m1 = step_reg - 3'd1;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                mul_x = a_lo;
                mul_y = b_lo;
            end
            2'd1:
            begin
                mul_x = a_lo;
                mul_y = b_hi;
            end
            2'd2:
            begin
                mul_x = a_hi;
                mul_y = b_lo;
            end
            default:
            begin
                mul_x = a_hi;
                mul_y = b_hi;
            end
        endcase
    end

    assign pp_next = (2*HW)'(mul_x) * (2*HW)'(mul_y);

    always_comb
    begin
        case (step_m1[1:0])
            2'd0:    pp_wide = PW'(pp_reg);
            2'd3:    pp_wide = PW'(pp_reg) << (2 * HW);
            default: pp_wide = PW'(pp_reg) << HW;
        endcase
    end

    assign mul_sum  = acc_reg + pp_wide;
    assign prod_lo  = mul_sum[LW-1:0];
    assign prod_hi  = mul_sum[2*LW-1:LW];
    assign mul_done = (step_reg == 3'(MUL_LAST_STEP));

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign start_bh   = is_first ? carry_in : borrow_high_reg;
    assign start_bb   = is_first ? 1'b0 : borrow_bit_reg;
    assign borrow_out = (start_bh > limb) || (start_bb && (start_bh >= limb));
    assign diff       = limb - start_bh - LW'(start_bb);

    assign shift_eff = ({1'b0, shift_reg} > (SHIFT_WIDTH + 1)'(LW - 1)) ?
                       SW'(LW - 1) : shift_reg[SW-1:0];
    assign top_bits  = (prod_lo << (SW'(LW - 1) - shift_eff)) << 1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire && (cfg_index == REG_DIVISOR))
                    state_next = S_INV_T;
                else if (in_fire)
                    state_next = S_QMUL;
            end
            S_QMUL:
            begin
                if (mul_done)
                    state_next = S_HMUL;
            end
            S_HMUL:
            begin
                if (mul_done)
                begin
                    if (emit_mid_reg)
                        state_next = S_EMIT_MID;
                    else if (last_reg)
                        state_next = S_EMIT_FIN;
                    else
                        state_next = S_IDLE;
                end
            end
            S_INV_T:
            begin
                if (mul_done)
                    state_next = S_INV_V;
            end
            S_INV_V:
            begin
                if (mul_done)
                begin
                    if (iter_reg == IW'(INV_ITERATIONS - 1))
                        state_next = S_IDLE;
                    else
                        state_next = S_INV_T;
                end
            end
            S_EMIT_MID:
            begin
                if (out_free)
                    state_next = last_reg ? S_EMIT_FIN : S_IDLE;
            end
            S_EMIT_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        divisor_next      = divisor_reg;
        inverse_next      = inverse_reg;
        shift_next        = shift_reg;
        borrow_high_next  = borrow_high_reg;
        borrow_bit_next   = borrow_bit_reg;
        pending_next      = pending_reg;
        have_pending_next = have_pending_reg;
        last_next         = last_reg;
        emit_mid_next     = emit_mid_reg;
        mid_next          = mid_reg;
        iter_next         = iter_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        step_next         = step_reg;
        acc_next          = acc_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_q_next        = out_q_reg;
        out_rem_next      = out_rem_reg;
        out_fin_next      = out_fin_reg;

        // advance the shared multiplier
        if ((state_reg == S_QMUL) || (state_reg == S_HMUL) ||
            (state_reg == S_INV_T) || (state_reg == S_INV_V))
        begin
            step_next = step_reg + 3'd1;
            acc_next  = (step_reg == 3'd0) ? '0 : mul_sum;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    if (cfg_index == REG_DIVISOR)
                    begin
                        divisor_next = cfg_data | LW'(1);
                        inverse_next = cfg_data | LW'(1);
                        mul_a_next   = cfg_data | LW'(1);
                        mul_b_next   = cfg_data | LW'(1);
                        iter_next    = '0;
                        step_next    = '0;
                    end
                    else if (cfg_index == REG_SHIFT)
                    begin
                        shift_next = cfg_data[SHIFT_WIDTH-1:0];
                    end
                end
                else if (in_fire)
                begin
                    borrow_bit_next   = borrow_out;
                    have_pending_next = is_first ? 1'b0 : have_pending_reg;
                    pending_next      = is_first ? '0 : pending_reg;
                    last_next         = is_last;
                    mul_a_next        = diff;
                    mul_b_next        = inverse_reg;
                    step_next         = '0;
                end
            end
            S_QMUL:
            begin
                if (mul_done)
                begin
                    mid_next          = pending_reg | top_bits;
                    emit_mid_next     = have_pending_reg;
                    pending_next      = prod_lo >> shift_eff;
                    have_pending_next = 1'b1;
                    mul_a_next        = prod_lo;
                    mul_b_next        = divisor_reg;
                    step_next         = '0;
                end
            end
            S_HMUL:
            begin
                if (mul_done)
                begin
                    borrow_high_next = prod_hi;
                    step_next        = '0;
                end
            end
            S_INV_T:
            begin
                if (mul_done)
                begin
                    mul_a_next = inverse_reg;
                    mul_b_next = LW'(2) - prod_lo;
                    step_next  = '0;
                end
            end
            S_INV_V:
            begin
                if (mul_done)
                begin
                    inverse_next = prod_lo;
                    iter_next    = iter_reg + IW'(1);
                    mul_a_next   = divisor_reg;
                    mul_b_next   = prod_lo;
                    step_next    = '0;
                end
            end
            S_EMIT_MID:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_q_next     = mid_reg;
                    out_rem_next   = '0;
                    out_fin_next   = 1'b0;
                end
            end
            S_EMIT_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_q_next        = pending_reg;
                    out_rem_next      = borrow_high_reg + LW'(borrow_bit_reg);
                    out_fin_next      = 1'b1;
                    borrow_high_next  = '0;
                    borrow_bit_next   = 1'b0;
                    pending_next      = '0;
                    have_pending_next = 1'b0;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            divisor_reg      <= LW'(1);
            inverse_reg      <= LW'(1);
            shift_reg        <= '0;
            borrow_high_reg  <= '0;
            borrow_bit_reg   <= 1'b0;
            pending_reg      <= '0;
            have_pending_reg <= 1'b0;
            last_reg         <= 1'b0;
            emit_mid_reg     <= 1'b0;
            iter_reg         <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            divisor_reg      <= divisor_next;
            inverse_reg      <= inverse_next;
            shift_reg        <= shift_next;
            borrow_high_reg  <= borrow_high_next;
            borrow_bit_reg   <= borrow_bit_next;
            pending_reg      <= pending_next;
            have_pending_reg <= have_pending_next;
            last_reg         <= last_next;
            emit_mid_reg     <= emit_mid_next;
            iter_reg         <= iter_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg     <= mid_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        pp_reg      <= pp_next;
        out_q_reg   <= out_q_next;
        out_rem_reg <= out_rem_next;
        out_fin_reg <= out_fin_next;
    end

    assign out_valid     = out_valid_reg;
    assign quotient_limb = out_q_reg;
    assign remainder     = out_rem_reg;
    assign final_flag    = out_fin_reg;

endmodule
